// File: src/x86arf_pkg.sv
`timescale 1ns / 1ps

package x86arf_pkg;

  localparam int VALUE_W     = 64;
  localparam int FLAGS_W     = 32;
  localparam int REG_IDX_W   = 4;
  localparam int FLAG_IDX_W  = 5;
  localparam int FUNC_W      = 3;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 72;

  // flags word bit positions
  localparam int FLAG_CF = 0;
  localparam int FLAG_ZF = 6;
  localparam int FLAG_SF = 7;
  localparam int FLAG_TF = 8;
  localparam int FLAG_OF = 11;

  typedef enum logic [FUNC_W-1:0] {
    FN_WR_REG   = 3'd0,
    FN_RD_REG   = 3'd1,
    FN_SET_MARK = 3'd2,
    FN_RD_MARK  = 3'd3,
    FN_WR_FLAGS = 3'd4,
    FN_RD_FLAGS = 3'd5,
    FN_TGL_FLAG = 3'd6,
    FN_SET_TRAP = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    SZ_BYTE  = 2'd0,
    SZ_WORD  = 2'd1,
    SZ_DWORD = 2'd2,
    SZ_QWORD = 2'd3
  } size_t;

  typedef struct packed {
    logic                 wr_en;
    logic                 mark_en;
    logic [REG_IDX_W-1:0] idx;
    size_t                size;
    logic                 high;
    logic [VALUE_W-1:0]   value;
    logic                 mark;
  } gpr_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] data;
    logic               mark;
  } gpr_rsp_t;

endpackage

// File: src/x86arf_gpr.sv
`timescale 1ns / 1ps

module x86arf_gpr #(
  parameter int NUM_REGS       = 16,
  parameter int HIGH_BYTE_REGS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  x86arf_pkg::gpr_req_t req,
  output x86arf_pkg::gpr_rsp_t rsp
);
  import x86arf_pkg::*;

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int EXT_W = (IDX_W > REG_IDX_W) ? IDX_W : REG_IDX_W;

  logic [VALUE_W-1:0]  regs_r [NUM_REGS];
  logic [NUM_REGS-1:0] marks_r;

  logic [EXT_W-1:0]   idx_ext;
  logic [IDX_W-1:0]   slot;
  logic               idx_ok;
  logic               use_hi;
  logic [VALUE_W-1:0] cur;
  logic [VALUE_W-1:0] merged;
  logic [VALUE_W-1:0] rd_data;

  assign idx_ext = EXT_W'(req.idx);
  assign slot    = idx_ext[IDX_W-1:0];
  assign idx_ok  = (32'(req.idx) < NUM_REGS);
  assign use_hi  = req.high && (32'(req.idx) < HIGH_BYTE_REGS);
  assign cur     = idx_ok ? regs_r[slot] : '0;

  always_comb begin
    merged  = cur;
    rd_data = cur;
    case (req.size)
      SZ_QWORD: begin
        merged  = req.value;
        rd_data = cur;
      end
      SZ_DWORD: begin
        merged  = {32'd0, req.value[31:0]};
        rd_data = {32'd0, cur[31:0]};
      end
      SZ_WORD: begin
        merged  = {cur[63:16], req.value[15:0]};
        rd_data = {48'd0, cur[15:0]};
      end
      default: begin
        if (use_hi) begin
          merged  = {cur[63:16], req.value[7:0], cur[7:0]};
          rd_data = {56'd0, cur[15:8]};
        end else begin
          merged  = {cur[63:8], req.value[7:0]};
          rd_data = {56'd0, cur[7:0]};
        end
      end
    endcase
  end

  assign rsp.data = rd_data;
  assign rsp.mark = idx_ok ? marks_r[slot] : 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
      marks_r <= '0;
    end else begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (req.wr_en && idx_ok && slot == IDX_W'(i)) begin
          regs_r[i] <= merged;
        end
        if (req.mark_en && idx_ok && slot == IDX_W'(i)) begin
          marks_r[i] <= req.mark;
        end
      end
    end
  end

  a_qword_write: assert property (@(posedge clk) disable iff (!rst_n)
    (req.wr_en && idx_ok && req.size == SZ_QWORD)
      |=> regs_r[$past(slot)] == $past(req.value))
    else $error("qword write not stored");

  a_dword_zext: assert property (@(posedge clk) disable iff (!rst_n)
    (req.wr_en && idx_ok && req.size == SZ_DWORD)
      |=> regs_r[$past(slot)][63:32] == 32'd0)
    else $error("dword write did not clear upper half");

  a_byte_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (req.wr_en && idx_ok && req.size == SZ_BYTE && !use_hi)
      |=> regs_r[$past(slot)][63:8] == $past(cur[63:8]))
    else $error("low byte write disturbed upper bits");

endmodule

// File: src/x86_aliased_register_file.sv
`timescale 1ns / 1ps
// x86 general purpose register file: NUM_REGS 64-bit registers with sized,
// aliased access (byte, high byte, word, dword with zero extension, qword),
// a sign mark per register and a 32-bit flags word.
// Requests arrive on the in_ stream; in_tuser carries the function code and
// in_tdata the operands. Every request produces exactly one result on the
// out_ stream: read data plus trap, carry, zero, sign and overflow flags
// as they stand after the request.
// The request is decoded, the register file and flags are read, modified and
// written, and the result is registered at the same edge. One request per
// cycle is sustained while out_tready stays high; the single read-modify-write
// pass through the register array sets that figure.
// When the receiver stalls, the result register holds and in_tready drops
// until it is taken; a request accepted in the cycle the result leaves is
// processed without a bubble.
// Synchronous reset clears all registers, sign marks, flags and out_tvalid.

module x86_aliased_register_file #(
  parameter int NUM_REGS       = 16,
  parameter int HIGH_BYTE_REGS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // reg_index[3:0], size_code[5:4], high_byte[6], value[70:7],
  // sign_mark[71], flag_index[76:72], zero pad [79:77]
  input  logic [x86arf_pkg::IN_TDATA_W-1:0]     in_tdata,
  // func[2:0]
  input  logic [x86arf_pkg::FUNC_W-1:0]         in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // read_data[63:0], trap_flag[64], carry_flag[65], zero_flag[66],
  // sign_flag[67], overflow_flag[68], zero pad [71:69]
  output logic [x86arf_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import x86arf_pkg::*;

  logic                   accept;
  func_t                  func;
  logic [FLAG_IDX_W-1:0]  flag_idx;
  gpr_req_t               gpr_req;
  gpr_rsp_t               gpr_rsp;

  logic [FLAGS_W-1:0]     flags_r, flags_nxt;
  logic [VALUE_W-1:0]     rd_data;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign func      = func_t'(in_tuser);
  assign flag_idx  = in_tdata[76:72];

  always_comb begin
    gpr_req.wr_en   = accept && func == FN_WR_REG;
    gpr_req.mark_en = accept && func == FN_SET_MARK;
    gpr_req.idx     = in_tdata[3:0];
    gpr_req.size    = size_t'(in_tdata[5:4]);
    gpr_req.high    = in_tdata[6];
    gpr_req.value   = in_tdata[70:7];
    gpr_req.mark    = in_tdata[71];
  end

  x86arf_gpr #(
    .NUM_REGS       (NUM_REGS),
    .HIGH_BYTE_REGS (HIGH_BYTE_REGS)
  ) u_gpr (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (gpr_req),
    .rsp   (gpr_rsp)
  );

  always_comb begin
    flags_nxt = flags_r;
    rd_data   = '0;
    unique case (func)
      FN_WR_REG:   rd_data = '0;
      FN_RD_REG:   rd_data = gpr_rsp.data;
      FN_SET_MARK: rd_data = '0;
      FN_RD_MARK:  rd_data = VALUE_W'(gpr_rsp.mark);
      FN_WR_FLAGS: flags_nxt = gpr_req.value[FLAGS_W-1:0];
      FN_RD_FLAGS: rd_data = VALUE_W'(flags_r);
      FN_TGL_FLAG: flags_nxt = flags_r ^ (FLAGS_W'(1) << flag_idx);
      FN_SET_TRAP: flags_nxt = flags_r | (FLAGS_W'(1) << FLAG_TF);
      default:     rd_data = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'd0, flags_nxt[FLAG_OF], flags_nxt[FLAG_SF],
                       flags_nxt[FLAG_ZF], flags_nxt[FLAG_CF],
                       flags_nxt[FLAG_TF], rd_data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        flags_r <= flags_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
